// File: hdl/kmrr_pkg.sv
// Shared types and constants for the key macro record/replay block.
// Used by kmrr_ctrl, kmrr_dp and the key_macro_record_replay top level.
package kmrr_pkg;

  // Default depth of the event store
  localparam int MAX_EVENTS_DEF = 32;

  // Configuration register indexes and widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_MACRO_KEY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_AFTER = 2'd2;

  // Register reset values
  localparam logic [7:0]  MACRO_KEY_RST   = 8'd0;
  localparam logic [15:0] CLICK_LIMIT_RST = 16'd250;
  localparam logic [15:0] CLEAR_AFTER_RST = 16'd2000;

  // Previous code marker for "no key seen yet"
  localparam logic [8:0] NO_KEY = 9'd256;

  // Operating mode of the recorder
  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_ACTIVATED = 2'd1,
    MODE_RECORDING = 2'd2
  } mode_t;

  // One key event request
  typedef struct packed {
    logic        key_down;
    logic [7:0]  key_code;
    logic [31:0] now_ms;
  } item_t;

  // One result
  typedef struct packed {
    logic       is_replay;
    logic       out_down;
    logic [7:0] out_code;
    logic       pass_on;
    logic       last;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;          // capture the incoming request
    logic commit;        // apply mode, store and history updates
    logic rd_start;      // read store entry zero
    logic rd_next;       // read the following store entry
    logic emit_replay;   // drive a replayed event
    logic emit_verdict;  // drive the final verdict
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    mode_t mode;
    logic  is_macro;
    logic  prev_match;
    logic  dt_lt_click;
    logic  fill_zero;
    logic  rd_last;
  } dp_status_t;

endpackage

// File: hdl/kmrr_ctrl.sv
// Sequencing controller for the key macro record/replay block.
// Depends on kmrr_pkg for the command and status structs.
module kmrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  kmrr_pkg::dp_status_t status,
  output kmrr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_REPLAY,
    S_VERDICT
  } state_t;

  state_t state;
  state_t state_next;
  logic   do_replay;

  // Replay: second macro-key event matching the armed key, within the click limit, with a non-empty store
  assign do_replay = (status.mode == kmrr_pkg::MODE_ACTIVATED) && status.is_macro &&
                     status.prev_match && status.dt_lt_click && !status.fill_zero;

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.commit = 1'b1;
        if (do_replay) begin
          cmd.rd_start = 1'b1;
          state_next   = S_REPLAY;
        end else begin
          cmd.emit_verdict = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_REPLAY: begin
        cmd.emit_replay = 1'b1;
        if (status.rd_last) begin
          state_next = S_VERDICT;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_VERDICT: begin
        cmd.emit_verdict = 1'b1;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/kmrr_dp.sv
// Datapath for the key macro record/replay block: config registers,
// mode and history registers, event store and the result register.
// Depends on kmrr_pkg for types and constants.
module kmrr_dp #(
  parameter int MAX_EVENTS = kmrr_pkg::MAX_EVENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kmrr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kmrr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  kmrr_pkg::item_t                     item,
  input  kmrr_pkg::ctrl_cmd_t                 cmd,
  output kmrr_pkg::dp_status_t                status,
  output kmrr_pkg::result_t                   result,
  output logic                                strobe
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_EVENTS + 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(MAX_EVENTS);

  // Configuration
  logic [7:0]  macro_key;
  logic [15:0] click_limit_ms;
  logic [15:0] clear_after_ms;

  // Architectural state
  kmrr_pkg::mode_t mode;
  logic [8:0]      prev_code;
  logic [31:0]     prev_time;
  logic [CW-1:0]   fill_count;
  logic [8:0]      event_store [MAX_EVENTS];

  // Working registers
  kmrr_pkg::item_t item_q;
  logic            pass_hold;
  logic [CW-1:0]   rd_idx;
  logic [8:0]      rd_data;

  logic [31:0]   dt;
  logic          is_macro;
  logic          prev_match;
  logic          dt_lt_click;
  logic          dt_gt_clear;
  logic          pass_now;
  logic          not_full;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] rd_idx_inc;

  // Decision terms on the captured request
  assign is_macro    = (item_q.key_code == macro_key);
  assign prev_match  = (prev_code == {1'b0, item_q.key_code});
  assign dt          = item_q.now_ms - prev_time;
  assign dt_lt_click = (dt < {16'd0, click_limit_ms});
  assign dt_gt_clear = (dt > {16'd0, clear_after_ms});
  assign not_full    = (fill_count < FILL_MAX);
  assign pass_now    = !(((mode == kmrr_pkg::MODE_RECORDING) ||
                          (mode == kmrr_pkg::MODE_ACTIVATED)) && !is_macro);

  assign rd_idx_inc = rd_idx + CW'(1);
  assign rd_addr    = cmd.rd_start ? '0 : rd_idx_inc;

  assign status.mode        = mode;
  assign status.is_macro    = is_macro;
  assign status.prev_match  = prev_match;
  assign status.dt_lt_click = dt_lt_click;
  assign status.fill_zero   = (fill_count == '0);
  assign status.rd_last     = (rd_idx_inc == fill_count);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      macro_key      <= kmrr_pkg::MACRO_KEY_RST;
      click_limit_ms <= kmrr_pkg::CLICK_LIMIT_RST;
      clear_after_ms <= kmrr_pkg::CLEAR_AFTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kmrr_pkg::CFG_MACRO_KEY:   macro_key      <= cfg_data[7:0];
        kmrr_pkg::CFG_CLICK_LIMIT: click_limit_ms <= cfg_data;
        kmrr_pkg::CFG_CLEAR_AFTER: clear_after_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  // Mode, history and fill count updates
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= kmrr_pkg::MODE_IDLE;
      prev_code  <= kmrr_pkg::NO_KEY;
      prev_time  <= '0;
      fill_count <= '0;
    end else if (cmd.commit) begin
      case (mode)
        kmrr_pkg::MODE_RECORDING: begin
          if (is_macro) begin
            mode <= kmrr_pkg::MODE_IDLE;
          end else if (not_full) begin
            fill_count <= fill_count + CW'(1);
          end
        end
        kmrr_pkg::MODE_ACTIVATED: begin
          if (is_macro) begin
            // long hold empties the store; short click replays (no change here)
            if (prev_match && !dt_lt_click && dt_gt_clear) begin
              fill_count <= '0;
            end
            mode <= kmrr_pkg::MODE_IDLE;
          end else begin
            // first recorded event starts a fresh macro
            mode       <= kmrr_pkg::MODE_RECORDING;
            fill_count <= CW'(1);
          end
        end
        default: begin
          mode      <= is_macro ? kmrr_pkg::MODE_ACTIVATED : kmrr_pkg::MODE_IDLE;
          prev_code <= {1'b0, item_q.key_code};
          prev_time <= item_q.now_ms;
        end
      endcase
    end
  end

  // Event store write and read
  always_ff @(posedge clk) begin
    if (cmd.commit && !is_macro) begin
      if (mode == kmrr_pkg::MODE_RECORDING && not_full) begin
        event_store[fill_count[AW-1:0]] <= {item_q.key_down, item_q.key_code};
      end else if (mode == kmrr_pkg::MODE_ACTIVATED) begin
        event_store[0] <= {item_q.key_down, item_q.key_code};
      end
    end
    if (cmd.rd_start || cmd.rd_next) begin
      rd_data <= event_store[rd_addr[AW-1:0]];
    end
  end

  // Replay index and held verdict
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx_inc;
    end
    if (cmd.commit) begin
      pass_hold <= pass_now;
    end
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_replay || cmd.emit_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_replay) begin
      result.is_replay <= 1'b1;
      result.out_down  <= rd_data[8];
      result.out_code  <= rd_data[7:0];
      result.pass_on   <= 1'b0;
      result.last      <= 1'b0;
    end else if (cmd.emit_verdict) begin
      result.is_replay <= 1'b0;
      result.out_down  <= 1'b0;
      result.out_code  <= '0;
      result.pass_on   <= cmd.commit ? pass_now : pass_hold;
      result.last      <= 1'b1;
    end
  end

endmodule

// File: hdl/key_macro_record_replay.sv
// Key macro recorder/replayer top level: controller plus datapath.
// A no-replay request is captured on accept; S_EVAL commits it and issues the verdict
// strobe, and busy is high only in S_EVAL. A replay holds busy through S_EVAL, an
// S_REPLAY per stored event (one store read per cycle) and S_VERDICT; results stream
// on consecutive cycles and the verdict follows the last one.
// Reset (rst, synchronous): idle mode, empty store, default config; store contents stay.
module key_macro_record_replay #(
  parameter int MAX_EVENTS = kmrr_pkg::MAX_EVENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  kmrr_pkg::item_t                  item,
  output kmrr_pkg::result_t                result,
  output logic                             strobe,
  input  logic                             cfg_we,
  input  logic [kmrr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kmrr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  kmrr_pkg::ctrl_cmd_t  cmd;
  kmrr_pkg::dp_status_t status;

  // Sequencer
  kmrr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Registers, store and result
  kmrr_dp #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .strobe    (strobe)
  );

endmodule
